>>> sv/stbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_pkg
// Types, constants and the S, P, L functions of the 512-bit compression step.
// ----------------------------------------------------------------------------
package stbc_pkg;

    localparam int unsigned WORDS        = 8;
    localparam int unsigned WORD_W       = 64;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned ROUNDS_DEF   = 12;
    localparam int unsigned KEY_ROWS     = 12;
    localparam int unsigned QUEUE_DEPTH  = 2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef t_word             t_vec [WORDS];

    typedef struct packed {
        t_idx  word_index;
        t_word h_word;
        t_word m_word;
        t_word n_word;
    } t_in_item;

    typedef struct packed {
        t_idx  out_index;
        t_word hash_word;
        logic  last_word;
    } t_out_item;

    localparam logic [7:0] SUB [256] = '{
     8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
     8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
     8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
     8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
     8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
     8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
     8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
     8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
     8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
     8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
     8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
     8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
     8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
     8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
     8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
     8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
    };

    // row j applies when bit (63 - j) is set
    localparam t_word MIX [64] = '{
     64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
     64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
     64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
     64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
     64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
     64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
     64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
     64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
     64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
     64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
     64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
     64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
     64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
     64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
     64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
     64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
    };

    localparam t_word RC [KEY_ROWS][WORDS] = '{
     '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
       64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
     '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
       64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
     '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
       64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
     '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
       64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
     '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
       64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
     '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
       64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
     '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
       64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
     '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
       64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
     '{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
       64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
     '{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
       64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
     '{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
       64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
     '{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
       64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
    };

    function automatic t_word mix_word(input t_word x);
        t_word r;
        r = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (x[j]) begin
                r = r ^ MIX[WORD_W-1-j];
            end
        end
        return r;
    endfunction

    // one output word k of LPS over the xor-ed vector x
    function automatic t_word lps_word(input t_vec x, input t_idx k);
        t_word w;
        w = '0;
        for (int n = 0; n < WORDS; n++) begin
            w[8*n +: 8] = SUB[x[n][8*k +: 8]];
        end
        return mix_word(w);
    endfunction

endpackage

>>> sv/stbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_in_if / stbc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface stbc_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               word_index;
    logic [63:0]              h_word;
    logic [63:0]              m_word;
    logic [63:0]              n_word;
    modport source (output valid, word_index, h_word, m_word, n_word, input ready);
    modport sink   (input valid, word_index, h_word, m_word, n_word, output ready);
endinterface

interface stbc_out_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               out_index;
    logic [63:0]              hash_word;
    logic                     last_word;
    modport source (output valid, out_index, hash_word, last_word, input ready);
    modport sink   (input valid, out_index, hash_word, last_word, output ready);
endinterface

>>> sv/stbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_front
// Accepts input items into a short queue ahead of the compression engine.
// ----------------------------------------------------------------------------
module stbc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stbc_in_if.sink               i_in,
    output logic                  o_q_valid,
    output stbc_pkg::t_in_item    o_q_item,
    input  logic                  i_q_pop
);
    import stbc_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_in_item         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;
    logic             push;

    assign i_in.ready = (r_cnt < (PTR_W+1)'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_item   = r_mem[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_q_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wr] <= '{i_in.word_index, i_in.h_word, i_in.m_word, i_in.n_word};
        end
    end
endmodule

>>> sv/stbc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_engine
// Stores h, m, N and runs the keyed LPS rounds one 64-bit word per cycle.
// ----------------------------------------------------------------------------
module stbc_engine #(
    parameter int unsigned ROUNDS = stbc_pkg::ROUNDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  stbc_pkg::t_in_item    i_q_item,
    output logic                  o_q_pop,
    stbc_out_if.source            o_out
);
    import stbc_pkg::*;

    localparam int unsigned RND_W = $clog2(ROUNDS + 1);

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_KEY0 = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_KEYS = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_vec             r_h, r_m, r_n, r_k, r_s, r_tk, r_ts;
    logic [RND_W-1:0] r_rnd, n_rnd;
    t_idx             r_w, n_w;
    logic             r_ov, n_ov;
    t_out_item        r_out;
    t_vec             xk, xs;
    logic             take;

    assign take    = (r_state == ST_LOAD) && i_q_valid;
    assign o_q_pop = take;

    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            xk[i] = (r_state == ST_KEY0) ? (r_h[i] ^ r_n[i])
                  : (r_k[i] ^ RC[r_rnd][i]);
            xs[i] = r_s[i] ^ r_k[i];
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_w     = r_w;
        n_ov    = r_ov;
        if (o_out.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            ST_LOAD: begin
                if (take && i_q_item.word_index == t_idx'(WORDS-1)) begin
                    n_state = ST_KEY0;
                    n_w     = '0;
                end
            end
            ST_KEY0: begin
                n_w = r_w + 1'b1;
                if (r_w == t_idx'(WORDS-1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_w = r_w + 1'b1;
                if (r_w == t_idx'(WORDS-1)) begin
                    n_state = ST_KEYS;
                end
            end
            ST_KEYS: begin
                n_w = r_w + 1'b1;
                if (r_w == t_idx'(WORDS-1)) begin
                    if (r_rnd == RND_W'(ROUNDS-1)) begin
                        n_rnd   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_rnd   = r_rnd + 1'b1;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov = 1'b1;
                    n_w  = r_w + 1'b1;
                    if (r_w == t_idx'(WORDS-1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_rnd   <= '0;
            r_w     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_w     <= n_w;
            r_ov    <= n_ov;
        end
        if (take) begin
            r_h[i_q_item.word_index] <= i_q_item.h_word;
            r_m[i_q_item.word_index] <= i_q_item.m_word;
            r_n[i_q_item.word_index] <= i_q_item.n_word;
        end
        case (r_state)
            ST_KEY0: begin
                r_tk[r_w] <= lps_word(xk, r_w);
                if (r_w == t_idx'(WORDS-1)) begin
                    for (int i = 0; i < WORDS-1; i++) r_k[i] <= r_tk[i];
                    r_k[WORDS-1] <= lps_word(xk, r_w);
                    r_s <= r_m;
                end
            end
            ST_ROUND: begin
                r_ts[r_w] <= lps_word(xs, r_w);
                if (r_w == t_idx'(WORDS-1)) begin
                    for (int i = 0; i < WORDS-1; i++) r_s[i] <= r_ts[i];
                    r_s[WORDS-1] <= lps_word(xs, r_w);
                end
            end
            ST_KEYS: begin
                r_tk[r_w] <= lps_word(xk, r_w);
                if (r_w == t_idx'(WORDS-1)) begin
                    for (int i = 0; i < WORDS-1; i++) r_k[i] <= r_tk[i];
                    r_k[WORDS-1] <= lps_word(xk, r_w);
                end
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    r_out <= '{r_w, r_s[r_w] ^ r_k[r_w] ^ r_h[r_w] ^ r_m[r_w],
                               r_w == t_idx'(WORDS-1)};
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_index = r_out.out_index;
    assign o_out.hash_word = r_out.hash_word;
    assign o_out.last_word = r_out.last_word;
endmodule

>>> sv/streebog_compression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streebog_compression
// Compression step g_N(h, m, N) of the 512-bit hash.
// ----------------------------------------------------------------------------
// Items carry one word each of h, m and N; index 7 completes a block. The engine
// has one LPS word unit and computes each 512-bit LPS pass word by word: the
// first key, then the rounds alternating state and key, then the output words.
// Input items are taken one per cycle via a two-entry queue while the engine is
// loading.
module streebog_compression #(
    parameter int unsigned ROUNDS = stbc_pkg::ROUNDS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    stbc_in_if.sink    i_in,
    stbc_out_if.source o_out
);
    import stbc_pkg::*;

    logic     q_valid, q_pop;
    t_in_item q_item;

    stbc_front u_front (
        .i_clk, .i_rst_n, .i_in,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    stbc_engine #(.ROUNDS(ROUNDS)) u_engine (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop), .o_out
    );
endmodule

>>> sv/stbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbc_checker
// Port-level properties of the compression block.
// ----------------------------------------------------------------------------
module stbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_index,
    input logic [63:0] hash_word,
    input logic       last_word
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (last_word == (out_index == 3'd7))) else $error("last flag");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ready && out_index != 3'd7) ##1 out_valid
        |-> out_index == $past(out_index) + 3'd1) else $error("order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hash_word)))
        else $error("hold");
endmodule

bind streebog_compression stbc_checker u_chk (
    .i_clk, .i_rst_n,
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_index(o_out.out_index),
    .hash_word(o_out.hash_word), .last_word(o_out.last_word)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 512-bit compression step. Words of h, m and N
// are streamed in with random gaps; every word 7 triggers a local g_N
// computation whose eight words are matched in order against the block's
// output channel, which is stalled at random.
// ----------------------------------------------------------------------------
module tb_top;
    import stbc_pkg::*;

    typedef struct {
        t_idx  idx;
        t_word h;
        t_word m;
        t_word n;
        logic  known;
        t_word hw;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    stbc_in_if  in_ch ();
    stbc_out_if out_ch ();

    streebog_compression dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    t_vec      h_vec, m_vec, n_vec;
    t_out_item hash_q [$];
    t_word     known_q [$];
    logic      known_f [$];
    int        n_err = 0;
    t_row      rows [$];

    function automatic t_word sbox_mix(input t_vec x, input int k);
        t_word w, r;
        w = '0;
        for (int n = 0; n < WORDS; n++) w[8*n +: 8] = SUB[x[n][8*k +: 8]];
        r = '0;
        for (int j = 0; j < WORD_W; j++) if (w[j]) r ^= MIX[WORD_W-1-j];
        return r;
    endfunction

    function automatic t_vec lps(input t_vec a, input t_vec b);
        t_vec x, t;
        for (int k = 0; k < WORDS; k++) x[k] = a[k] ^ b[k];
        for (int k = 0; k < WORDS; k++) t[k] = sbox_mix(x, k);
        return t;
    endfunction

    task automatic compress_block(input logic kn, input t_word kw);
        t_vec key, st, c;
        t_out_item o;
        key = lps(h_vec, n_vec);
        st = m_vec;
        for (int r = 0; r < ROUNDS_DEF; r++) begin
            st = lps(st, key);
            for (int k = 0; k < WORDS; k++) c[k] = RC[r % KEY_ROWS][k];
            key = lps(key, c);
        end
        for (int k = 0; k < WORDS; k++) begin
            o.out_index = t_idx'(k);
            o.hash_word = st[k] ^ key[k] ^ h_vec[k] ^ m_vec[k];
            o.last_word = (k == WORDS - 1);
            hash_q.push_back(o);
            known_f.push_back(kn && k == 0);
            known_q.push_back(kw);
        end
    endtask

    // leaves valid high at the falling edge after acceptance
    task automatic send_word(input t_row r);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.word_index <= r.idx;
        in_ch.h_word     <= r.h;
        in_ch.m_word     <= r.m;
        in_ch.n_word     <= r.n;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        h_vec[r.idx] = r.h;
        m_vec[r.idx] = r.m;
        n_vec[r.idx] = r.n;
        if (r.idx == 3'd7) compress_block(r.known, r.hw);
        @(negedge i_clk);
    endtask

    function automatic t_word rnd64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_row mk(input int i, input t_word h, m, n);
        t_row r;
        r.idx = t_idx'(i); r.h = h; r.m = m; r.n = n; r.known = 1'b0; r.hw = '0;
        return r;
    endfunction

    task automatic add_block(input bit shuffle);
        int ord [8];
        for (int i = 0; i < 8; i++) ord[i] = i;
        if (shuffle) ord.shuffle();
        for (int i = 0; i < 8; i++)
            if (ord[i] != 7) rows.push_back(mk(ord[i], rnd64(), rnd64(), rnd64()));
        if ($urandom_range(0, 3) == 0)
            rows.push_back(mk($urandom_range(0, 6), rnd64(), rnd64(), rnd64()));
        rows.push_back(mk(7, rnd64(), rnd64(), rnd64()));
    endtask

    // output side: random wait per item, in-order compare
    initial begin
        t_out_item e;
        logic kn;
        t_word kw;
        int w;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            w = $urandom_range(0, 11);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && out_ch.valid));
            if (hash_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item idx=%0d", out_ch.out_index);
            end else begin
                e = hash_q.pop_front();
                kn = known_f.pop_front();
                kw = known_q.pop_front();
                if (out_ch.out_index !== e.out_index || out_ch.hash_word !== e.hash_word ||
                    out_ch.last_word !== e.last_word || (kn && out_ch.hash_word !== kw)) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %0d %h %b got %0d %h %b", e.out_index,
                                 e.hash_word, e.last_word, out_ch.out_index,
                                 out_ch.hash_word, out_ch.last_word);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_row r;
        in_ch.valid = 1'b0;
        in_ch.word_index = '0;
        in_ch.h_word = '0;
        in_ch.m_word = '0;
        in_ch.n_word = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: all-zero block, all-ones,
        // then an overwritten position and a recompute from retained stores
        for (int i = 0; i < 8; i++) rows.push_back(mk(i, '0, '0, '0));
        for (int i = 0; i < 8; i++) rows.push_back(mk(i, '1, '1, '1));
        for (int i = 0; i < 7; i++)
            rows.push_back(mk(i, {$urandom, $urandom}, {$urandom, $urandom}, 64'h200));
        rows.push_back(mk(2, '1, '0, '1));
        rows.push_back(mk(7, 64'h8000_0000_0000_0000, 64'h1, 64'h0));
        rows.push_back(mk(7, 64'h1, 64'h8000_0000_0000_0000, 64'h5555_aaaa_5555_aaaa));
        foreach (rows[i]) send_word(rows[i]);
        in_ch.valid <= 1'b0;
        rows = {};
        // quiet point: drain before random traffic
        wait (hash_q.size() == 0);
        for (int b = 0; b < 35; b++) add_block(b % 3 != 0);
        foreach (rows[i]) send_word(rows[i]);
        in_ch.valid <= 1'b0;
        wait (hash_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_err == 0 && hash_q.size() == 0) begin
            $display("[streebog_compression] OK");
        end else begin
            $display("[streebog_compression] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[streebog_compression] ERROR");
        $finish;
    end
endmodule
